[rtl/taog_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taog_pkg
// Shared widths, register indexes and reset values for the temperature
// average and outlier gate.
// ----------------------------------------------------------------------------
package taog_pkg;

	// Samples kept in the averaging ring
	localparam int WINDOW_LEN = 5;

	localparam int RAW_W     = 16;
	localparam int LIMIT_W   = 12;
	localparam int TIME_W    = 32;
	localparam int CENTI_W   = 19;
	localparam int SUM_W     = 20;
	localparam int DIFF_W    = SUM_W + 2;
	localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int COUNT_W   = $clog2(WINDOW_LEN + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_OUTLIER_LIMIT = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_VALID_FLOOR   = cfg_idx_t'(1);

	localparam logic [LIMIT_W-1:0]      OUTLIER_LIMIT_RST = LIMIT_W'(80);
	localparam logic signed [RAW_W-1:0] VALID_FLOOR_RST   = -16'sd1600;

endpackage

[rtl/taog_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taog channel interfaces
// Valid/ready channels for sensor items, result items and register writes.
// ----------------------------------------------------------------------------
interface taog_sample_if;
	logic                               valid;
	logic                               ready;
	logic                               sensor_present;
	logic signed [taog_pkg::RAW_W-1:0]  raw_reading;
	logic [taog_pkg::TIME_W-1:0]        now_ms;

	modport source (output valid, sensor_present, raw_reading, now_ms, input ready);
	modport sink   (input valid, sensor_present, raw_reading, now_ms, output ready);
endinterface

interface taog_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [taog_pkg::CENTI_W-1:0] centidegrees;
	logic [taog_pkg::TIME_W-1:0]         elapsed_ms;

	modport source (output valid, centidegrees, elapsed_ms, input ready);
	modport sink   (input valid, centidegrees, elapsed_ms, output ready);
endinterface

interface taog_cfg_if;
	logic                              valid;
	logic                              ready;
	taog_pkg::cfg_idx_t                index;
	logic [taog_pkg::CFG_DAT_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/temperature_average_outlier_gate_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_average_outlier_gate_core
// Moving average over the last stored readings with an outlier gate;
// emits readings in centidegrees and the time since the previous result.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the skid entry is empty. The ring,
// running sum and gate compare (count times reading, limit times count)
// settle in the cycle an item is accepted, and a passing reading is
// registered in the output register, or in the skid entry when the output
// register holds an untaken result. Behind the output register sits a
// one-entry skid stage: the sample channel stays ready until both hold
// results, so ready drops only after two results wait untaken. Dropped
// readings (sensor absent, at or below the floor, outliers) give no result;
// outliers are still stored in the ring. Register writes are always taken.
module temperature_average_outlier_gate_core (
	input  logic                   clk,
	input  logic                   arst_n,
	taog_sample_if.sink            sample,
	taog_result_if.source          result,
	taog_cfg_if.sink               cfg
);

	// configuration
	logic [taog_pkg::LIMIT_W-1:0]      outlier_limit_q;
	logic signed [taog_pkg::RAW_W-1:0] valid_floor_q;

	// window state
	logic signed [taog_pkg::RAW_W-1:0] ring_q [taog_pkg::WINDOW_LEN];
	logic [taog_pkg::SLOT_W-1:0]       slot_q;
	logic                              filled_q;
	logic signed [taog_pkg::SUM_W-1:0] sum_q;
	logic [taog_pkg::TIME_W-1:0]       last_emit_q;

	// output register and skid entry
	logic                                out_valid_q;
	logic signed [taog_pkg::CENTI_W-1:0] out_cd_q;
	logic [taog_pkg::TIME_W-1:0]         out_el_q;
	logic                                skid_valid_q;
	logic signed [taog_pkg::CENTI_W-1:0] skid_cd_q;
	logic [taog_pkg::TIME_W-1:0]         skid_el_q;

	// datapath
	logic                                accept;
	logic                                store;
	logic                                emit;
	logic                                take;
	logic signed [taog_pkg::RAW_W-1:0]   old_sample;
	logic signed [taog_pkg::SUM_W-1:0]   sum_next;
	logic                                last_slot;
	logic [taog_pkg::SLOT_W-1:0]         slot_next;
	logic                                filled_next;
	logic [taog_pkg::COUNT_W-1:0]        count;
	logic signed [taog_pkg::DIFF_W-1:0]  count_prod;
	logic signed [taog_pkg::DIFF_W-1:0]  diff;
	logic [taog_pkg::DIFF_W-1:0]         abs_diff;
	logic [taog_pkg::DIFF_W-1:0]         bound;
	logic signed [taog_pkg::RAW_W+4:0]   raw_x;
	logic signed [taog_pkg::RAW_W+4:0]   raw_x25;
	logic signed [taog_pkg::RAW_W+4:0]   raw_x25_adj;
	logic signed [taog_pkg::CENTI_W-1:0] cd_new;
	logic [taog_pkg::TIME_W-1:0]         elapsed_new;

	assign cfg.ready    = 1'b1;
	assign sample.ready = !skid_valid_q;

	assign accept = sample.valid && sample.ready;
	assign store  = accept && sample.sensor_present && (sample.raw_reading > valid_floor_q);
	assign take   = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outlier_limit_q <= taog_pkg::OUTLIER_LIMIT_RST;
			valid_floor_q   <= taog_pkg::VALID_FLOOR_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				taog_pkg::CFG_OUTLIER_LIMIT: outlier_limit_q <= cfg.data[taog_pkg::LIMIT_W-1:0];
				taog_pkg::CFG_VALID_FLOOR:   valid_floor_q   <= signed'(cfg.data[taog_pkg::RAW_W-1:0]);
				default: ;
			endcase
		end
	end

	// ring update and running sum
	always_comb begin
		old_sample  = ring_q[slot_q];
		sum_next    = sum_q
		              - (filled_q ? taog_pkg::SUM_W'(old_sample) : '0)
		              + taog_pkg::SUM_W'(sample.raw_reading);
		last_slot   = (slot_q == taog_pkg::SLOT_W'(taog_pkg::WINDOW_LEN - 1));
		slot_next   = last_slot ? '0 : slot_q + 1'b1;
		filled_next = filled_q || last_slot;
		count       = filled_next ? taog_pkg::COUNT_W'(taog_pkg::WINDOW_LEN)
		                          : taog_pkg::COUNT_W'(slot_q) + 1'b1;
	end

	// gate: |sum - count*raw| <= limit*count
	always_comb begin
		count_prod = taog_pkg::DIFF_W'(sample.raw_reading)
		             * signed'(taog_pkg::DIFF_W'(count));
		diff       = taog_pkg::DIFF_W'(sum_next) - count_prod;
		abs_diff   = diff[taog_pkg::DIFF_W-1] ? unsigned'(-diff) : unsigned'(diff);
		bound      = taog_pkg::DIFF_W'(outlier_limit_q) * taog_pkg::DIFF_W'(count);
		emit       = store && (abs_diff <= bound);
	end

	// raw * 25 / 4, truncated toward zero
	always_comb begin
		raw_x       = (taog_pkg::RAW_W+5)'(sample.raw_reading);
		raw_x25     = (raw_x <<< 4) + (raw_x <<< 3) + raw_x;
		raw_x25_adj = raw_x25 + (raw_x25[taog_pkg::RAW_W+4]
		                         ? (taog_pkg::RAW_W+5)'(3) : (taog_pkg::RAW_W+5)'(0));
		cd_new      = raw_x25_adj[taog_pkg::CENTI_W+1:2];
		elapsed_new = sample.now_ms - last_emit_q;
	end

	// ring entries are undefined until written and need no reset
	always_ff @(posedge clk) begin
		if (store) begin
			ring_q[slot_q] <= sample.raw_reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			filled_q    <= 1'b0;
			sum_q       <= '0;
			last_emit_q <= '0;
		end else begin
			if (store) begin
				slot_q   <= slot_next;
				filled_q <= filled_next;
				sum_q    <= sum_next;
			end
			if (emit) begin
				last_emit_q <= sample.now_ms;
			end
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q  <= skid_valid_q || emit;
				skid_valid_q <= 1'b0;
			end else if (emit) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= out_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			out_cd_q <= skid_cd_q;
			out_el_q <= skid_el_q;
		end else if (emit && (take || !out_valid_q)) begin
			out_cd_q <= cd_new;
			out_el_q <= elapsed_new;
		end
		// park the item when the output register still holds an untaken result
		if (emit && out_valid_q && !take) begin
			skid_cd_q <= cd_new;
			skid_el_q <= elapsed_new;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.centidegrees = out_cd_q;
	assign result.elapsed_ms   = out_el_q;

endmodule

[dv/temperature_average_outlier_gate_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_average_outlier_gate_core_test
// Drives sensor items through the averaging outlier gate under random
// back-pressure and checks every result against a cycle-free predictor of
// the ring, the running sum, the gate and the centidegree conversion.
// ----------------------------------------------------------------------------
module temperature_average_outlier_gate_core_test;

	// Indexes past the register list; writes to them must be ignored
	localparam taog_pkg::cfg_idx_t CFG_SPARE_A = taog_pkg::cfg_idx_t'(2);
	localparam taog_pkg::cfg_idx_t CFG_SPARE_B = taog_pkg::cfg_idx_t'(3);

	typedef struct {
		logic signed [taog_pkg::CENTI_W-1:0] centi;
		logic [taog_pkg::TIME_W-1:0]         elapsed;
	} temp_result_t;

	logic clk;
	logic arst_n;

	taog_sample_if sample_ch ();
	taog_result_if result_ch ();
	taog_cfg_if    cfg_ch ();

	temperature_average_outlier_gate_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state, mirrors the block after reset
	logic signed [taog_pkg::RAW_W-1:0] window_ring [taog_pkg::WINDOW_LEN];
	int                                window_slot = 0;
	bit                                window_full = 1'b0;
	longint                            window_sum  = 0;
	logic [taog_pkg::TIME_W-1:0]       last_emit   = '0;
	logic [taog_pkg::LIMIT_W-1:0]      limit_q     = taog_pkg::OUTLIER_LIMIT_RST;
	logic signed [taog_pkg::RAW_W-1:0] floor_q     = taog_pkg::VALID_FLOOR_RST;

	temp_result_t expected_results [$];

	bit                          steady = 1'b0;
	int                          failures = 0;
	int                          items_sent = 0;
	int                          results_seen = 0;
	int                          register_writes = 0;
	int                          level = 0;
	logic [taog_pkg::TIME_W-1:0] clock_ms = '0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(negedge clk) begin
		result_ch.ready = steady || ($urandom_range(99) >= 23);
	end

	// Update the window with one reading; return 1 when it passes the gate
	function automatic bit predict_reading(input bit present,
			input logic signed [taog_pkg::RAW_W-1:0] raw,
			input logic [taog_pkg::TIME_W-1:0] now,
			output temp_result_t res);
		int     slot;
		longint count;
		longint gap;
		longint centi;
		if (!present || raw <= floor_q)
			return 1'b0;
		slot = window_slot;
		if (window_full)
			window_sum -= longint'(window_ring[slot]);
		window_ring[slot] = raw;
		window_sum += longint'(raw);
		slot++;
		if (slot >= taog_pkg::WINDOW_LEN) begin
			slot = 0;
			window_full = 1'b1;
		end
		window_slot = slot;
		count = window_full ? longint'(taog_pkg::WINDOW_LEN) : longint'(slot);
		gap = window_sum - count * longint'(raw);
		if (gap < 0)
			gap = -gap;
		if (gap > longint'(limit_q) * count)
			return 1'b0;
		// SV division truncates toward zero, as required
		centi = (longint'(raw) * 25) / 4;
		res.centi = taog_pkg::CENTI_W'(centi);
		res.elapsed = now - last_emit;
		last_emit = now;
		return 1'b1;
	endfunction

	always @(posedge clk) begin : check_results
		temp_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				failures++;
				$error("result with nothing pending: centidegrees %0d, elapsed_ms %0d",
					result_ch.centidegrees, result_ch.elapsed_ms);
			end else begin
				want = expected_results.pop_front();
				if (result_ch.centidegrees !== want.centi) begin
					failures++;
					$error("centidegrees: expected %0d, actual %0d",
						want.centi, result_ch.centidegrees);
				end
				if (result_ch.elapsed_ms !== want.elapsed) begin
					failures++;
					$error("elapsed_ms: expected %0d, actual %0d",
						want.elapsed, result_ch.elapsed_ms);
				end
			end
		end
	end

	task automatic send_reading(input bit present,
			input logic signed [taog_pkg::RAW_W-1:0] raw,
			input logic [taog_pkg::TIME_W-1:0] now);
		temp_result_t res;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 23) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.sensor_present = present;
		sample_ch.raw_reading = raw;
		sample_ch.now_ms = now;
		do @(posedge clk); while (!sample_ch.ready);
		if (predict_reading(present, raw, now, res))
			expected_results.push_back(res);
		items_sent++;
	endtask

	// Hold the sender until every pending result is out and the pipe is quiet
	task automatic wait_drained();
		@(negedge clk) sample_ch.valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input taog_pkg::cfg_idx_t idx,
			input logic [taog_pkg::CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			taog_pkg::CFG_OUTLIER_LIMIT: limit_q = data[taog_pkg::LIMIT_W-1:0];
			taog_pkg::CFG_VALID_FLOOR:   floor_q = data;
			default: ;
		endcase
		register_writes++;
		@(negedge clk) cfg_ch.valid = 1'b0;
	endtask

	task automatic set_phase(input logic [taog_pkg::LIMIT_W-1:0] lim, input int flr);
		int lo;
		wait_drained();
		write_register(taog_pkg::CFG_OUTLIER_LIMIT, {4'($urandom), lim});
		write_register(taog_pkg::CFG_VALID_FLOOR, taog_pkg::CFG_DAT_W'(flr));
		lo = flr + 700;
		if (lo > 32000)
			level = 32767;
		else
			level = lo + int'($urandom_range(32000 - lo));
	endtask

	// Mostly readings near the current level, plus outliers, absent sensors, readings at or below the floor and noise
	task automatic send_random_reading();
		int pick;
		int jit;
		int r;
		bit present;
		pick = $urandom_range(99);
		present = 1'b1;
		jit = (limit_q / 2 > 600) ? 600 : int'(limit_q) / 2;
		level += int'($urandom_range(16)) - 8;
		if (pick < 70)
			r = level + int'($urandom_range(2 * jit)) - jit;
		else if (pick < 80)
			r = level + ((pick % 2) ? 1 : -1) * (int'(limit_q) + 1 + int'($urandom_range(300)));
		else if (pick < 88) begin
			present = 1'b0;
			r = int'($urandom);
		end else if (pick < 94)
			r = int'(floor_q) - int'($urandom_range(50));
		else
			r = int'($signed(taog_pkg::RAW_W'($urandom)));
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		clock_ms += ($urandom_range(99) < 3) ? $urandom : $urandom_range(1500, 1);
		send_reading(present, taog_pkg::RAW_W'(r), clock_ms);
	endtask

	task automatic test_drop_rules();
		send_reading(1'b0, 16'sd400, 32'd10);
		send_reading(1'b1, taog_pkg::VALID_FLOOR_RST, 32'd20);
		send_reading(1'b1, -16'sd32768, 32'd30);
	endtask

	// Fill the ring from empty, with one outlier that is stored anyway
	task automatic test_warmup_and_outlier();
		send_reading(1'b1, -16'sd1599, 32'd1000);
		send_reading(1'b1, -16'sd1540, 32'd1100);
		send_reading(1'b1, 16'sd2000, 32'd1200);
		send_reading(1'b1, -16'sd1500, 32'd1300);
		send_reading(1'b1, -16'sd1560, 32'd1400);
		send_reading(1'b1, -16'sd1580, 32'd1500);
	endtask

	task automatic test_extreme_readings();
		set_phase(taog_pkg::LIMIT_W'(4095), -32768);
		repeat (5) send_reading(1'b1, 16'sd32767, 32'd2000);
		repeat (5) send_reading(1'b1, -16'sd32767, 32'd2100);
		send_reading(1'b1, -16'sd32768, 32'd2200);
	endtask

	// Zero limit: only readings equal to the window average pass; time runs across the wrap
	task automatic test_time_wrap();
		set_phase(taog_pkg::LIMIT_W'(0), int'(taog_pkg::VALID_FLOOR_RST));
		repeat (4) send_reading(1'b1, 16'sd160, 32'hFFFF_FFE0);
		send_reading(1'b1, 16'sd160, 32'hFFFF_FFF0);
		send_reading(1'b1, 16'sd160, 32'd5);
		send_reading(1'b1, 16'sd161, 32'd7);
		wait_drained();
		write_register(CFG_SPARE_A, taog_pkg::CFG_DAT_W'($urandom));
		write_register(CFG_SPARE_B, taog_pkg::CFG_DAT_W'($urandom));
		send_reading(1'b1, -16'sd3, 32'd9);
		clock_ms = 32'd9;
	endtask

	task automatic test_register_sweep();
		set_phase(taog_pkg::LIMIT_W'(0), -32768);
		repeat (40) send_random_reading();
		set_phase(taog_pkg::LIMIT_W'(4095), -32768);
		repeat (40) send_random_reading();
		repeat (2) begin
			set_phase(taog_pkg::LIMIT_W'($urandom_range(4095)),
				int'($urandom_range(52768)) - 32768);
			repeat (40) send_random_reading();
		end
		set_phase(taog_pkg::LIMIT_W'($urandom_range(4095)), 32767);
		repeat (15) send_random_reading();
	endtask

	task automatic test_random_stream();
		set_phase(taog_pkg::OUTLIER_LIMIT_RST, int'(taog_pkg::VALID_FLOOR_RST));
		for (int i = 0; i < 340; i++) begin
			steady = (i >= 100 && i < 200);
			if (i == 250)
				wait_drained();
			if (i == 170)
				set_phase(taog_pkg::LIMIT_W'($urandom_range(400, 20)), -2000);
			send_random_reading();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.sensor_present = 1'b0;
		sample_ch.raw_reading = '0;
		sample_ch.now_ms = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = taog_pkg::CFG_OUTLIER_LIMIT;
		cfg_ch.data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_drop_rules();
		test_warmup_and_outlier();
		test_extreme_readings();
		test_time_wrap();
		test_register_sweep();
		test_random_stream();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d sensor items and checked %0d results over %0d register writes,",
			items_sent, results_seen, register_writes);
		$display("covering drops, warm-up, outliers, extreme readings and time wrap.");
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/taog_pkg.sv
rtl/taog_ifs.sv
rtl/temperature_average_outlier_gate_core.sv
dv/temperature_average_outlier_gate_core_test.sv
